FILE: rtl/cbts_pkg.sv
// Shared types, widths and constants of the channel breakout trailing-stop block.
// Used by cbts_core and the top level; depends on nothing.
`default_nettype none

package cbts_pkg;

  localparam int PRICE_W    = 32;
  localparam int EQ_W       = 56;
  localparam int PNL_W      = 48;
  localparam int PV_W       = 16;
  localparam int SLP_W      = 32;
  localparam int SF_W       = 16;
  localparam int STOP_W     = PRICE_W + 1;
  localparam int A_W        = PRICE_W + 2;
  localparam int B_W        = SF_W + 1;
  localparam int DELTA_W    = PRICE_W + 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = EQ_W;
  localparam int DIGIT_W_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_VALUE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIPPAGE_COST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_FRACTION  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_EQUITY = 2'd3;

  localparam logic [PV_W-1:0]         PV_RESET  = 16'd1000;
  localparam logic [SLP_W-1:0]        SLP_RESET = 32'd1245184;
  localparam logic [SF_W-1:0]         SF_RESET  = 16'd655;
  localparam logic signed [EQ_W-1:0]  EQ_RESET  = 56'sd6553600000;

  typedef logic signed [1:0] pos_t;
  localparam pos_t POS_FLAT  = 2'sb00;
  localparam pos_t POS_LONG  = 2'sb01;
  localparam pos_t POS_SHORT = 2'sb11;

  localparam logic [1:0] HALVES_NONE = 2'd0;
  localparam logic [1:0] HALVES_ONE  = 2'd1;
  localparam logic [1:0] HALVES_TWO  = 2'd2;

  typedef struct packed {
    logic [PV_W-1:0]        point_value;
    logic [SLP_W-1:0]       slippage_cost;
    logic [SF_W-1:0]        stop_fraction;
    logic signed [EQ_W-1:0] initial_equity;
  } cfg_t;

  typedef struct packed {
    logic               run_start;
    logic               run_last;
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic [PRICE_W-1:0] bar_close;
    logic [PRICE_W-1:0] channel_high;
    logic [PRICE_W-1:0] channel_low;
  } in_t;

  typedef struct packed {
    pos_t                    position_out;
    logic signed [PNL_W-1:0] bar_pnl;
    logic signed [EQ_W-1:0]  equity_out;
    logic signed [EQ_W-1:0]  drawdown_out;
    logic [1:0]              trade_halves;
    logic                    last_out;
  } out_t;

endpackage

`default_nettype wire

FILE: rtl/cbts_mul.sv
// Digit-serial signed by unsigned multiplier, one digit of the multiplier per cycle.
// Depends on nothing; widths come from the instantiating module.
`default_nettype none

module cbts_mul #(
  parameter int A_W     = 34,
  parameter int B_W     = 17,
  parameter int DIGIT_W = 4
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [A_W-1:0]    a,
  input  wire logic [B_W-1:0]           b,
  output logic                          done,
  output logic signed [A_W+((B_W+DIGIT_W-1)/DIGIT_W)*DIGIT_W-1:0] product
);

  localparam int NDIG  = (B_W + DIGIT_W - 1) / DIGIT_W;
  localparam int NB    = NDIG * DIGIT_W;
  localparam int CNT_W = $clog2(NDIG + 1);

  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      done_r, done_nxt;
  logic signed [A_W-1:0]     a_r, a_nxt;
  logic [NB-1:0]             b_r, b_nxt;
  logic signed [A_W-1:0]     hi_r, hi_nxt;
  logic [NB-1:0]             lo_r, lo_nxt;
  logic signed [A_W+DIGIT_W-1:0] part;
  logic signed [A_W+DIGIT_W-1:0] sum;

  always_comb begin
    part     = (A_W+DIGIT_W)'(a_r * $signed({1'b0, b_r[DIGIT_W-1:0]}));
    sum      = (A_W+DIGIT_W)'(hi_r) + part;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    a_nxt    = a_r;
    b_nxt    = b_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    if (start) begin
      a_nxt   = a;
      b_nxt   = NB'(b);
      hi_nxt  = '0;
      lo_nxt  = '0;
      cnt_nxt = CNT_W'(NDIG);
    end else if (cnt_r != '0) begin
      b_nxt    = b_r >> DIGIT_W;
      hi_nxt   = sum[A_W+DIGIT_W-1:DIGIT_W];
      lo_nxt   = {sum[DIGIT_W-1:0], lo_r[NB-1:DIGIT_W]};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    a_r  <= a_nxt;
    b_r  <= b_nxt;
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign done    = done_r;
  assign product = $signed({hi_r, lo_r});

endmodule

`default_nettype wire

FILE: rtl/cbts_core.sv
// Bar sequencer: position, stops, P&L and equity, driving one shared serial multiplier.
// Depends on cbts_pkg and cbts_mul.
`default_nettype none

module cbts_core import cbts_pkg::*; #(
  parameter int DIGIT_W = DIGIT_W_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  input  wire cfg_t cfg,
  output logic      res_valid,
  input  wire logic res_ack,
  output out_t      res_data
);

  localparam int PROD_W = A_W + ((B_W + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
  localparam logic [B_W-1:0]          B_ONE   = {1'b1, {SF_W{1'b0}}};
  localparam logic signed [PNL_W-1:0] PNL_MAX = {1'b0, {(PNL_W-1){1'b1}}};
  localparam logic signed [PNL_W-1:0] PNL_MIN = {1'b1, {(PNL_W-1){1'b0}}};
  localparam logic signed [EQ_W-1:0]  EQ_MAX  = {1'b0, {(EQ_W-1){1'b1}}};
  localparam logic signed [EQ_W-1:0]  EQ_MIN  = {1'b1, {(EQ_W-1){1'b0}}};

  typedef enum logic [13:0] {
    ST_IDLE    = 14'h0001,
    ST_CARRY   = 14'h0002,
    ST_CARRY_W = 14'h0004,
    ST_FLAT    = 14'h0008,
    ST_FLAT_W  = 14'h0010,
    ST_LSTOP   = 14'h0020,
    ST_LSTOP_W = 14'h0040,
    ST_LTERM_W = 14'h0080,
    ST_SSTOP   = 14'h0100,
    ST_SSTOP_W = 14'h0200,
    ST_STERM_W = 14'h0400,
    ST_EQ      = 14'h0800,
    ST_DD      = 14'h1000,
    ST_OUT     = 14'h2000
  } state_t;

  function automatic logic signed [A_W-1:0] sdiff(input logic [STOP_W-1:0] x,
                                                   input logic [STOP_W-1:0] y);
    return $signed(A_W'(x)) - $signed(A_W'(y));
  endfunction

  function automatic logic signed [PNL_W-1:0] sat_pnl(input logic signed [DELTA_W-1:0] v);
    logic [DELTA_W-PNL_W:0] top;
    top = v[DELTA_W-1:PNL_W-1];
    if (top == '0 || top == '1) begin
      return v[PNL_W-1:0];
    end else if (v[DELTA_W-1]) begin
      return PNL_MIN;
    end else begin
      return PNL_MAX;
    end
  endfunction

  state_t                    state_r, state_nxt;
  in_t                       item_r, item_nxt;
  pos_t                      pos_r, pos_nxt;
  logic [PRICE_W-1:0]        prev_r, prev_nxt;
  logic [PRICE_W-1:0]        lpeak_r, lpeak_nxt;
  logic [PRICE_W-1:0]        strough_r, strough_nxt;
  logic signed [EQ_W-1:0]    equity_r, equity_nxt;
  logic signed [EQ_W-1:0]    peak_r, peak_nxt;
  logic signed [DELTA_W-1:0] delta_r, delta_nxt;
  logic [1:0]                halves_r, halves_nxt;
  logic signed [PNL_W-1:0]   pnl_r, pnl_nxt;
  logic signed [EQ_W-1:0]    dd_r, dd_nxt;

  logic                      mul_start, mul_done;
  logic signed [A_W-1:0]     mul_a;
  logic [B_W-1:0]            mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic signed [DELTA_W-1:0] p_d, slp_d, half_d;
  logic [STOP_W-1:0]         stop_now, cl_e, hi_e, lo_e, chh_e, cll_e;
  logic                      up, down, lex, sex;
  logic signed [PNL_W-1:0]   pnl_now;
  logic signed [EQ_W:0]      eq_sum, dd_full;
  logic signed [EQ_W-1:0]    peak_new;

  cbts_mul #(
    .A_W     (A_W),
    .B_W     (B_W),
    .DIGIT_W (DIGIT_W)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_comb begin
    p_d      = DELTA_W'(mul_p);
    slp_d    = $signed(DELTA_W'(cfg.slippage_cost));
    half_d   = $signed(DELTA_W'(cfg.slippage_cost >> 1));
    stop_now = STOP_W'(mul_p >>> 16);
    cl_e     = STOP_W'(item_r.bar_close);
    hi_e     = STOP_W'(item_r.bar_high);
    lo_e     = STOP_W'(item_r.bar_low);
    chh_e    = STOP_W'(item_r.channel_high);
    cll_e    = STOP_W'(item_r.channel_low);
    up       = item_r.bar_high >= item_r.channel_high;
    down     = item_r.bar_low <= item_r.channel_low;
    lex      = lo_e <= stop_now;
    sex      = hi_e >= stop_now;
    pnl_now  = sat_pnl(delta_r);
    eq_sum   = (EQ_W+1)'(equity_r) + (EQ_W+1)'(pnl_now);
    peak_new = (equity_r > peak_r) ? equity_r : peak_r;
    dd_full  = (EQ_W+1)'(equity_r) - (EQ_W+1)'(peak_new);

    state_nxt   = state_r;
    item_nxt    = item_r;
    pos_nxt     = pos_r;
    prev_nxt    = prev_r;
    lpeak_nxt   = lpeak_r;
    strough_nxt = strough_r;
    equity_nxt  = equity_r;
    peak_nxt    = peak_r;
    delta_nxt   = delta_r;
    halves_nxt  = halves_r;
    pnl_nxt     = pnl_r;
    dd_nxt      = dd_r;
    mul_start   = 1'b0;
    mul_a       = sdiff(cl_e, STOP_W'(prev_r));
    mul_b       = B_W'(cfg.point_value);
    res_valid   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          item_nxt   = in_data;
          delta_nxt  = '0;
          halves_nxt = HALVES_NONE;
          state_nxt  = ST_CARRY;
        end
      end
      ST_CARRY: begin
        if (item_r.run_start) begin
          pos_nxt    = POS_FLAT;
          equity_nxt = cfg.initial_equity;
          peak_nxt   = cfg.initial_equity;
          state_nxt  = ST_FLAT;
        end else if (pos_r != POS_FLAT) begin
          mul_start = 1'b1;
          state_nxt = ST_CARRY_W;
        end else begin
          state_nxt = ST_FLAT;
        end
      end
      ST_CARRY_W: begin
        if (mul_done) begin
          delta_nxt = (pos_r == POS_LONG) ? p_d : -p_d;
          state_nxt = ST_FLAT;
        end
      end
      ST_FLAT: begin
        if (pos_r == POS_FLAT) begin
          if (up || down) begin
            mul_start = 1'b1;
            mul_a     = (up && down) ? sdiff(cll_e, chh_e) :
                        up           ? sdiff(cl_e, chh_e) : sdiff(cl_e, cll_e);
            state_nxt = ST_FLAT_W;
          end else begin
            state_nxt = ST_EQ;
          end
        end else if (pos_r == POS_LONG) begin
          state_nxt = ST_LSTOP;
        end else if (pos_r == POS_SHORT) begin
          state_nxt = ST_SSTOP;
        end else begin
          state_nxt = ST_EQ;
        end
      end
      ST_FLAT_W: begin
        if (mul_done) begin
          if (up && down) begin
            delta_nxt  = p_d - slp_d;
            halves_nxt = HALVES_TWO;
          end else if (up) begin
            delta_nxt  = p_d - half_d;
            pos_nxt    = POS_LONG;
            lpeak_nxt  = item_r.bar_high;
            halves_nxt = HALVES_ONE;
          end else begin
            delta_nxt   = -p_d - half_d;
            pos_nxt     = POS_SHORT;
            strough_nxt = item_r.bar_low;
            halves_nxt  = HALVES_ONE;
          end
          state_nxt = ST_EQ;
        end
      end
      ST_LSTOP: begin
        mul_start = 1'b1;
        mul_a     = $signed(A_W'(lpeak_r));
        mul_b     = B_ONE - B_W'(cfg.stop_fraction);
        state_nxt = ST_LSTOP_W;
      end
      ST_LSTOP_W: begin
        if (mul_done) begin
          if (item_r.bar_high > lpeak_r) begin
            lpeak_nxt = item_r.bar_high;
          end
          if (down || lex) begin
            mul_start = 1'b1;
            mul_a     = down ? sdiff(cl_e, cll_e) : sdiff(cl_e, stop_now);
            state_nxt = ST_LTERM_W;
          end else begin
            state_nxt = ST_EQ;
          end
        end
      end
      ST_LTERM_W: begin
        if (mul_done) begin
          if (down) begin
            delta_nxt   = delta_r - slp_d - (p_d <<< 1);
            pos_nxt     = POS_SHORT;
            strough_nxt = item_r.bar_low;
            halves_nxt  = HALVES_TWO;
            state_nxt   = ST_SSTOP;
          end else begin
            delta_nxt  = delta_r - half_d - p_d;
            pos_nxt    = POS_FLAT;
            halves_nxt = HALVES_ONE;
            state_nxt  = ST_EQ;
          end
        end
      end
      ST_SSTOP: begin
        mul_start = 1'b1;
        mul_a     = $signed(A_W'(strough_r));
        mul_b     = B_ONE + B_W'(cfg.stop_fraction);
        state_nxt = ST_SSTOP_W;
      end
      ST_SSTOP_W: begin
        if (mul_done) begin
          if (item_r.bar_low < strough_r) begin
            strough_nxt = item_r.bar_low;
          end
          if (up || sex) begin
            mul_start = 1'b1;
            mul_a     = up ? sdiff(cl_e, chh_e) : sdiff(cl_e, stop_now);
            state_nxt = ST_STERM_W;
          end else begin
            state_nxt = ST_EQ;
          end
        end
      end
      ST_STERM_W: begin
        if (mul_done) begin
          if (up) begin
            delta_nxt  = delta_r - slp_d + (p_d <<< 1);
            pos_nxt    = POS_LONG;
            lpeak_nxt  = item_r.bar_high;
            halves_nxt = HALVES_TWO;
          end else begin
            delta_nxt  = delta_r - half_d + p_d;
            pos_nxt    = POS_FLAT;
            halves_nxt = HALVES_ONE;
          end
          state_nxt = ST_EQ;
        end
      end
      ST_EQ: begin
        pnl_nxt = pnl_now;
        if (eq_sum[EQ_W] != eq_sum[EQ_W-1]) begin
          equity_nxt = eq_sum[EQ_W] ? EQ_MIN : EQ_MAX;
        end else begin
          equity_nxt = eq_sum[EQ_W-1:0];
        end
        state_nxt = ST_DD;
      end
      ST_DD: begin
        peak_nxt = peak_new;
        dd_nxt   = (dd_full[EQ_W] != dd_full[EQ_W-1]) ? EQ_MIN : dd_full[EQ_W-1:0];
        prev_nxt = item_r.bar_close;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= POS_FLAT;
      prev_r    <= '0;
      lpeak_r   <= '0;
      strough_r <= '0;
      equity_r  <= EQ_RESET;
      peak_r    <= EQ_RESET;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      prev_r    <= prev_nxt;
      lpeak_r   <= lpeak_nxt;
      strough_r <= strough_nxt;
      equity_r  <= equity_nxt;
      peak_r    <= peak_nxt;
    end
    item_r   <= item_nxt;
    delta_r  <= delta_nxt;
    halves_r <= halves_nxt;
    pnl_r    <= pnl_nxt;
    dd_r     <= dd_nxt;
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    res_data.position_out = pos_r;
    res_data.bar_pnl      = pnl_r;
    res_data.equity_out   = equity_r;
    res_data.drawdown_out = dd_r;
    res_data.trade_halves = halves_r;
    res_data.last_out     = item_r.run_last;
  end

endmodule

`default_nettype wire

FILE: rtl/channel_breakout_trailing_stop_top.sv
// Top level of the channel breakout trailing-stop block: configuration registers,
// result register and checks. Depends on cbts_pkg and cbts_core.
//
// One word on in_data is one price bar; one word on out_data is the result of it.
// Both channels use valid and stall: a word moves at a rising edge with valid high
// and stall low. The block works on one bar at a time and raises in_stall from the
// cycle after a bar is taken until its result has entered the output register.
// All products go through one serial multiplier that takes DIGIT_W bits of its
// second operand per cycle. A bar needs none to five products: a flat bar with no
// breakout needs none, and a long position reversed to short and then stopped on
// the same bar needs all five. The result register frees the core, so the next
// bar may be taken while a result still waits on out_stall; a stalled result holds
// until taken. The configuration port writes one register per cycle with cfg_we;
// it is to be written only while the block is idle, and the initial equity takes
// effect at the next bar that starts a run. Synchronous reset loads the register
// defaults, a flat position and equity at its reset value.
`default_nettype none

module channel_breakout_trailing_stop_top import cbts_pkg::*; #(
  parameter int DIGIT_W = DIGIT_W_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_t                       out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic res_valid, res_ack;
  out_t res_data;

  cbts_core #(
    .DIGIT_W (DIGIT_W)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res_ack   (res_ack),
    .res_data  (res_data)
  );

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_POINT_VALUE:    cfg_nxt.point_value    = cfg_data[PV_W-1:0];
        CFG_SLIPPAGE_COST:  cfg_nxt.slippage_cost  = cfg_data[SLP_W-1:0];
        CFG_STOP_FRACTION:  cfg_nxt.stop_fraction  = cfg_data[SF_W-1:0];
        CFG_INITIAL_EQUITY: cfg_nxt.initial_equity = $signed(cfg_data[EQ_W-1:0]);
      endcase
    end
  end

  assign res_ack = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = (out_valid_r && out_stall) || (res_valid && res_ack);
    out_data_nxt  = (res_valid && res_ack) ? res_data : out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.point_value    <= PV_RESET;
      cfg_r.slippage_cost  <= SLP_RESET;
      cfg_r.stop_fraction  <= SF_RESET;
      cfg_r.initial_equity <= EQ_RESET;
      out_valid_r          <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("bar taken but the core did not go busy");

  a_drawdown_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.drawdown_out[EQ_W-1] || out_data.drawdown_out == '0))
    else $error("drawdown above zero");

  a_position_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.position_out == POS_FLAT || out_data.position_out == POS_LONG ||
                   out_data.position_out == POS_SHORT))
    else $error("position code out of range");

  a_halves_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.trade_halves == HALVES_NONE || out_data.trade_halves == HALVES_ONE ||
                   out_data.trade_halves == HALVES_TWO))
    else $error("trade size out of range");

endmodule

`default_nettype wire
